[rtl/core/sdx_pkg.sv]
// Package: shared types, constants and letter classification for the Soundex encoder.
`timescale 1ns / 1ps

package sdx_pkg;

    localparam logic [6:0] CHAR_ZERO = 7'd48;
    localparam logic [7:0] CASE_GAP  = 8'd32;
    localparam logic [7:0] CHAR_LO_A = 8'h61;
    localparam logic [7:0] CHAR_LO_Z = 8'h7A;
    localparam logic [7:0] CHAR_UP_A = 8'h41;
    localparam logic [7:0] CHAR_UP_Z = 8'h5A;

    // class of one byte after the front end has looked at it
    typedef enum logic [1:0] {
        KIND_SKIP   = 2'd0,
        KIND_LETTER = 2'd1,
        KIND_STOP   = 2'd2
    } sdx_kind_t;

    // classified item handed from front to back through the queue
    typedef struct packed {
        sdx_kind_t  kind;
        logic [6:0] letter;
        logic [2:0] digit;
        logic       vowel;
        logic       last;
    } sdx_item_t;

    function automatic logic [2:0] letter_digit(input logic [6:0] u);
        logic [2:0] d;
        unique case (u)
            "B", "F", "P", "V":                     d = 3'd1;
            "C", "G", "J", "K", "Q", "S", "X", "Z": d = 3'd2;
            "D", "T":                               d = 3'd3;
            "L":                                    d = 3'd4;
            "M", "N":                               d = 3'd5;
            "R":                                    d = 3'd6;
            default:                                d = 3'd0;
        endcase
        return d;
    endfunction

    function automatic logic is_merge_break(input logic [6:0] u);
        return (u == "A") || (u == "E") || (u == "I") || (u == "O") ||
               (u == "U") || (u == "Y");
    endfunction

endpackage

[rtl/core/sdx_if.sv]
// Interfaces: valid/ready channels for input bytes and output codes.
`timescale 1ns / 1ps

interface sdx_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_char;
    logic       word_end;

    modport source (output valid, output in_char, output word_end, input ready);
    modport sink   (input valid, input in_char, input word_end, output ready);
endinterface

interface sdx_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] lead_char;
    logic [5:0] digit_one;
    logic [5:0] digit_two;
    logic [5:0] digit_three;

    modport source (output valid, output lead_char, output digit_one,
                    output digit_two, output digit_three, input ready);
    modport sink   (input valid, input lead_char, input digit_one,
                    input digit_two, input digit_three, output ready);
endinterface

[rtl/core/soundex_encoder.sv]
// Top level: American Soundex encoder, one byte per item, one code per word.
//
//  channel    | dir | payload                                        | item
//  -----------+-----+------------------------------------------------+-----------------------
//  word_chan  | in  | in_char[7:0], word_end                         | one byte of a word
//  code_chan  | out | lead_char[6:0], digit_one/two/three[5:0]       | one code per word
//
//  Throughput: one byte per cycle while the queue has room; the front classifies in the
//  cycle of acceptance, the back applies the coding rules to one queued item per cycle,
//  save while a word-closing item waits on a stalled code_chan. A code is registered
//  in the result register when its closing item leaves the queue head.
//  Reset: rst_n clears queue pointers, word state and the result valid at once;
//  no clearing pass.
//  Stalls: a stalled code_chan holds only the next word-closing item in the
//  queue; word_chan sees backpressure once the queue fills (QUEUE_DEPTH items).
`timescale 1ns / 1ps

module soundex_encoder #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    sdx_in_if.sink           word_chan,
    sdx_out_if.source        code_chan
);
    import sdx_pkg::*;

    sdx_item_t front_item;
    sdx_item_t head_item;
    logic      queue_full;
    logic      queue_valid;
    logic      queue_pop;

    sdx_front u_front (
        .in_char  (word_chan.in_char),
        .word_end (word_chan.word_end),
        .item     (front_item)
    );

    // queue decouples classification from the coding state
    sdx_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (word_chan.valid),
        .push_item (front_item),
        .full      (queue_full),
        .pop       (queue_pop),
        .valid     (queue_valid),
        .head      (head_item)
    );

    assign word_chan.ready = !queue_full;

    sdx_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (queue_valid),
        .item        (head_item),
        .pop         (queue_pop),
        .out_valid   (code_chan.valid),
        .out_ready   (code_chan.ready),
        .lead_char   (code_chan.lead_char),
        .digit_one   (code_chan.digit_one),
        .digit_two   (code_chan.digit_two),
        .digit_three (code_chan.digit_three)
    );

endmodule

[rtl/core/sdx_front.sv]
// Front end: folds case and classifies each input byte into a queue item.
`timescale 1ns / 1ps

module sdx_front (
    input  logic [7:0]        in_char,
    input  logic              word_end,
    output sdx_pkg::sdx_item_t item
);
    import sdx_pkg::*;

    logic [7:0] upper;
    logic       alpha;

    always_comb
    begin
        upper = in_char;
        if (in_char >= CHAR_LO_A && in_char <= CHAR_LO_Z)
        begin
            upper = in_char - CASE_GAP;
        end
        alpha = (upper >= CHAR_UP_A) && (upper <= CHAR_UP_Z);

        item.letter = upper[6:0];
        item.digit  = letter_digit(upper[6:0]);
        item.vowel  = is_merge_break(upper[6:0]);
        item.last   = word_end;
        priority if (in_char == 8'd0)
        begin
            item.kind = KIND_STOP;
        end
        else if (alpha)
        begin
            item.kind = KIND_LETTER;
        end
        else
        begin
            item.kind = KIND_SKIP;
        end
    end

endmodule

[rtl/core/sdx_queue.sv]
// Queue: short FIFO of classified items between front and back.
`timescale 1ns / 1ps

module sdx_queue #(
    parameter int DEPTH = 2
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  sdx_pkg::sdx_item_t push_item,
    output logic               full,
    input  logic               pop,
    output logic               valid,
    output sdx_pkg::sdx_item_t head
);
    import sdx_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    sdx_item_t        mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign valid   = (count_reg != '0);
    assign head    = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count missed a push");

    a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers differ while empty");

endmodule

[rtl/core/sdx_back.sv]
// Back end: runs the Soundex coding rules and holds the result register.
`timescale 1ns / 1ps

module sdx_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    input  sdx_pkg::sdx_item_t item,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [6:0]         lead_char,
    output logic [5:0]         digit_one,
    output logic [5:0]         digit_two,
    output logic [5:0]         digit_three
);
    import sdx_pkg::*;

    logic       seen_letter_reg, seen_letter_next;
    logic [6:0] first_letter_reg, first_letter_next;
    logic [2:0] prev_code_reg, prev_code_next;
    logic [1:0] digits_done_reg, digits_done_next;
    logic [2:0] code_digit_reg [3];
    logic [2:0] code_digit_next [3];
    logic       word_stopped_reg, word_stopped_next;
    logic       out_valid_reg, out_valid_next;
    logic [6:0] lead_char_reg;
    logic [5:0] digit_one_reg, digit_two_reg, digit_three_reg;
    logic       emit;

    // a word-closing item waits only while an unread result still sits here
    assign pop  = item_valid && (!item.last || !out_valid_reg || out_ready);
    assign emit = pop && item.last;

    always_comb
    begin
        seen_letter_next  = seen_letter_reg;
        first_letter_next = first_letter_reg;
        prev_code_next    = prev_code_reg;
        digits_done_next  = digits_done_reg;
        code_digit_next   = code_digit_reg;
        word_stopped_next = word_stopped_reg;

        if (pop && !word_stopped_reg)
        begin
            if (item.kind == KIND_STOP)
            begin
                word_stopped_next = 1'b1;
            end
            else if (item.kind == KIND_LETTER)
            begin
                if (!seen_letter_reg)
                begin
                    seen_letter_next  = 1'b1;
                    first_letter_next = item.letter;
                    prev_code_next    = item.digit;
                end
                else if (digits_done_reg != 2'd3)
                begin
                    if (item.vowel)
                    begin
                        prev_code_next = 3'd0;
                    end
                    else if (item.digit != 3'd0 && item.digit != prev_code_reg)
                    begin
                        code_digit_next[digits_done_reg] = item.digit;
                        digits_done_next = digits_done_reg + 2'd1;
                        prev_code_next   = item.digit;
                    end
                end
            end
        end

        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_letter_reg  <= 1'b0;
            first_letter_reg <= CHAR_ZERO;
            prev_code_reg    <= 3'd0;
            digits_done_reg  <= 2'd0;
            code_digit_reg   <= '{3'd0, 3'd0, 3'd0};
            word_stopped_reg <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (emit)
            begin
                // word done: clear the word state for the next one
                seen_letter_reg  <= 1'b0;
                first_letter_reg <= CHAR_ZERO;
                prev_code_reg    <= 3'd0;
                digits_done_reg  <= 2'd0;
                code_digit_reg   <= '{3'd0, 3'd0, 3'd0};
                word_stopped_reg <= 1'b0;
            end
            else
            begin
                seen_letter_reg  <= seen_letter_next;
                first_letter_reg <= first_letter_next;
                prev_code_reg    <= prev_code_next;
                digits_done_reg  <= digits_done_next;
                code_digit_reg   <= code_digit_next;
                word_stopped_reg <= word_stopped_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            lead_char_reg   <= seen_letter_next ? first_letter_next : CHAR_ZERO;
            digit_one_reg   <= CHAR_ZERO[5:0] + {3'd0, code_digit_next[0]};
            digit_two_reg   <= CHAR_ZERO[5:0] + {3'd0, code_digit_next[1]};
            digit_three_reg <= CHAR_ZERO[5:0] + {3'd0, code_digit_next[2]};
        end
    end

    assign out_valid   = out_valid_reg;
    assign lead_char   = lead_char_reg;
    assign digit_one   = digit_one_reg;
    assign digit_two   = digit_two_reg;
    assign digit_three = digit_three_reg;

    a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> out_valid_reg)
        else $error("closing item did not raise a result");

    a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> (!seen_letter_reg && digits_done_reg == 2'd0 && !word_stopped_reg))
        else $error("word state not cleared after result");

    a_no_digit_early: assert property (@(posedge clk) disable iff (!rst_n)
        !seen_letter_reg |-> (digits_done_reg == 2'd0))
        else $error("code digit before first letter");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !emit)
        else $error("result overwritten while stalled");

endmodule
